// File: rtl/ltc_pkg.sv
// ----------------------------------------------------------------------------
// ltc_pkg
// Shared widths, register codes and constants of the lightmap texel combiner.
// ----------------------------------------------------------------------------
package ltc_pkg;

    // Parameter defaults for the top level
    localparam int MAX_STYLES_DEF      = 4;
    localparam int SCALE_FRAC_BITS_DEF = 8;

    // Fixed field widths
    localparam int STYLE_SLOTS = 4;
    localparam int NUM_CHAN    = 3;
    localparam int NUM_LANES   = 4;   // red, green, blue, alpha
    localparam int CHAN_W      = 8;
    localparam int SAMPLE_W    = NUM_CHAN * CHAN_W;
    localparam int SCALE_W     = 16;
    localparam int PROD_W      = CHAN_W + SCALE_W;
    localparam int CFG_DATA_W  = NUM_CHAN * SCALE_W;
    localparam int CFG_INDEX_W = 3;
    localparam int ACTIVE_W    = 3;
    localparam int QUOT_W      = 8;

    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

    // Lane order through the normaliser
    localparam int LANE_RED   = 0;
    localparam int LANE_GREEN = 1;
    localparam int LANE_BLUE  = 2;
    localparam int LANE_ALPHA = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SCALE_STYLE0  = 3'd0,
        REG_SCALE_STYLE1  = 3'd1,
        REG_SCALE_STYLE2  = 3'd2,
        REG_SCALE_STYLE3  = 3'd3,
        REG_ACTIVE_STYLES = 3'd4,
        REG_FULL_BRIGHT   = 3'd5
    } cfg_reg_t;

endpackage

// File: rtl/ltc_cfg_if.sv
// ----------------------------------------------------------------------------
// ltc_cfg_if
// Register write channel: valid, ready, register index and write data.
// ----------------------------------------------------------------------------
interface ltc_cfg_if;

    logic                               valid;
    logic                               ready;
    logic [ltc_pkg::CFG_INDEX_W-1:0]    index;
    logic [ltc_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);

endinterface

// File: rtl/ltc_texel_if.sv
// ----------------------------------------------------------------------------
// ltc_texel_if
// Texel input channel: one packed RGB sample per light style.
// ----------------------------------------------------------------------------
interface ltc_texel_if;

    logic                           valid;
    logic                           ready;
    logic [ltc_pkg::SAMPLE_W-1:0]   sample_style0;
    logic [ltc_pkg::SAMPLE_W-1:0]   sample_style1;
    logic [ltc_pkg::SAMPLE_W-1:0]   sample_style2;
    logic [ltc_pkg::SAMPLE_W-1:0]   sample_style3;

    modport source (
        output valid, output sample_style0, output sample_style1,
        output sample_style2, output sample_style3, input ready
    );
    modport sink (
        input valid, input sample_style0, input sample_style1,
        input sample_style2, input sample_style3, output ready
    );

endinterface

// File: rtl/ltc_result_if.sv
// ----------------------------------------------------------------------------
// ltc_result_if
// Result channel: combined and normalised RGBA8 texel.
// ----------------------------------------------------------------------------
interface ltc_result_if;

    logic                           valid;
    logic                           ready;
    logic [ltc_pkg::CHAN_W-1:0]     red_out;
    logic [ltc_pkg::CHAN_W-1:0]     green_out;
    logic [ltc_pkg::CHAN_W-1:0]     blue_out;
    logic [ltc_pkg::CHAN_W-1:0]     alpha_out;

    modport source (
        output valid, output red_out, output green_out, output blue_out,
        output alpha_out, input ready
    );
    modport sink (
        input valid, input red_out, input green_out, input blue_out,
        input alpha_out, output ready
    );

endinterface

// File: rtl/ltc_div.sv
// ----------------------------------------------------------------------------
// ltc_div
// Pipelined restoring divider, one quotient bit per stage, several lanes.
// Caller guarantees num < den << QUOT_W so the quotient fits.
// ----------------------------------------------------------------------------
module ltc_div #(
    parameter int LANES  = 4,
    parameter int NUM_W  = 26,
    parameter int DEN_W  = 18,
    parameter int QUOT_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [NUM_W-1:0]  in_num  [LANES],
    input  logic [DEN_W-1:0]  in_den  [LANES],
    output logic              out_valid,
    input  logic              out_ready,
    output logic [QUOT_W-1:0] out_quot [LANES]
);

    localparam int LAST = QUOT_W - 1;

    logic              valid_reg [QUOT_W];
    logic              stage_ready [QUOT_W];
    logic [QUOT_W-1:0] quot_reg [QUOT_W][LANES];
    // remainder and divisor are not needed after the last stage
    logic [NUM_W-1:0]  rem_reg [LAST][LANES];
    logic [DEN_W-1:0]  den_reg [LAST][LANES];

    genvar k, l;
    generate
        for (k = 0; k < QUOT_W; k++) begin : g_stage
            localparam int BIT = QUOT_W - 1 - k;

            logic [NUM_W-1:0]  rem_in   [LANES];
            logic [DEN_W-1:0]  den_in   [LANES];
            logic [QUOT_W-1:0] quot_in  [LANES];
            logic              valid_in;
            logic [NUM_W-1:0]  rem_next [LANES];
            logic [QUOT_W-1:0] quot_next [LANES];

            if (k == 0) begin : g_first
                assign valid_in = in_valid;
                for (l = 0; l < LANES; l++) begin : g_lane
                    assign rem_in[l]  = in_num[l];
                    assign den_in[l]  = in_den[l];
                    assign quot_in[l] = '0;
                end
            end else begin : g_rest
                assign valid_in = valid_reg[k-1];
                for (l = 0; l < LANES; l++) begin : g_lane
                    assign rem_in[l]  = rem_reg[k-1][l];
                    assign den_in[l]  = den_reg[k-1][l];
                    assign quot_in[l] = quot_reg[k-1][l];
                end
            end

            if (k == LAST) begin : g_ready_last
                assign stage_ready[k] = !valid_reg[k] || out_ready;
            end else begin : g_ready_mid
                assign stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
            end

            for (l = 0; l < LANES; l++) begin : g_step
                logic [NUM_W-1:0] trial;
                logic             fits;
                assign trial = NUM_W'(den_in[l]) << BIT;
                assign fits  = rem_in[l] >= trial;
                always_comb
                begin
                    rem_next[l]       = fits ? (rem_in[l] - trial) : rem_in[l];
                    quot_next[l]      = quot_in[l];
                    quot_next[l][BIT] = fits;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[k] <= 1'b0;
                end
                else if (stage_ready[k])
                begin
                    valid_reg[k] <= valid_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (stage_ready[k] && valid_in)
                begin
                    quot_reg[k] <= quot_next;
                end
            end

            if (k < LAST) begin : g_keep
                always_ff @(posedge clk)
                begin
                    if (stage_ready[k] && valid_in)
                    begin
                        rem_reg[k] <= rem_next;
                        den_reg[k] <= den_in;
                    end
                end
            end
        end
    endgenerate

    assign in_ready  = stage_ready[0];
    assign out_valid = valid_reg[LAST];
    assign out_quot  = quot_reg[LAST];

endmodule

// File: rtl/lightmap_texel_combine_top.sv
// ----------------------------------------------------------------------------
// lightmap_texel_combine_top
// Lightmap texel combine and normalise: scales up to four styled RGB samples,
// sums them, and rescales the texel so that no channel exceeds 255.
// ----------------------------------------------------------------------------
//
//  channel  | role   | beat carries
//  ---------+--------+------------------------------------------------------
//  cfg      | sink   | index (register number), data (48-bit write value)
//  texel    | sink   | sample_style0..3, packed RGB bytes, red lowest
//  result   | source | red_out, green_out, blue_out, alpha_out
//
//  Throughput is one texel per clock while the result port is not stalled. A
//  texel passes three stages for multiply, sum and setup, then eight stages
//  of the divider, one quotient bit per stage, before it shows on the result
//  port.
//  Every stage holds its own valid bit; a stage only stalls when it is full
//  and the next one cannot take its beat, so bubbles close up under stall.
//  Reset clears all valid bits and loads the registers with their defaults
//  (unity scales, one active style, full bright off). cfg is always ready.
//
module lightmap_texel_combine_top #(
    parameter int MAX_STYLES      = ltc_pkg::MAX_STYLES_DEF,
    parameter int SCALE_FRAC_BITS = ltc_pkg::SCALE_FRAC_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    ltc_cfg_if.sink      cfg,
    ltc_texel_if.sink    texel,
    ltc_result_if.source result
);

    // Sum of up to MAX_STYLES products, then drop the fraction bits
    localparam int SUM_W = ltc_pkg::PROD_W + $clog2(MAX_STYLES);
    localparam int V_W   = SUM_W - SCALE_FRAC_BITS;
    localparam int NUM_W = V_W + ltc_pkg::QUOT_W;
    localparam int DEN_W = V_W;
    localparam int LANES = ltc_pkg::NUM_LANES;
    localparam int CH    = ltc_pkg::NUM_CHAN;
    localparam int CW    = ltc_pkg::CHAN_W;
    localparam int SW    = ltc_pkg::SCALE_W;

    localparam logic [SW-1:0] SCALE_ONE = SW'(1) << SCALE_FRAC_BITS;
    localparam logic [ltc_pkg::CFG_DATA_W-1:0] SCALE_UNITY = {CH{SCALE_ONE}};
    localparam logic [ltc_pkg::ACTIVE_W-1:0] ACTIVE_MAX =
        ltc_pkg::ACTIVE_W'(MAX_STYLES);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [ltc_pkg::CFG_DATA_W-1:0] scale_reg [MAX_STYLES];
    logic [ltc_pkg::ACTIVE_W-1:0]   active_reg;
    logic                           full_bright_reg;
    logic                           cfg_write;
    ltc_pkg::cfg_reg_t              cfg_code;

    assign cfg.ready = 1'b1;
    assign cfg_write = cfg.valid && cfg.ready;
    assign cfg_code  = ltc_pkg::cfg_reg_t'(cfg.index);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < MAX_STYLES; s++)
            begin
                scale_reg[s] <= SCALE_UNITY;
            end
            active_reg      <= ltc_pkg::ACTIVE_W'(1);
            full_bright_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            // Scale slots beyond MAX_STYLES are never summed: drop those writes
            for (int s = 0; s < MAX_STYLES; s++)
            begin
                if (cfg.index == (ltc_pkg::CFG_INDEX_W'(ltc_pkg::REG_SCALE_STYLE0)
                                  + ltc_pkg::CFG_INDEX_W'(s)))
                begin
                    scale_reg[s] <= cfg.data;
                end
            end
            unique case (cfg_code)
                ltc_pkg::REG_ACTIVE_STYLES:
                begin
                    active_reg <= cfg.data[ltc_pkg::ACTIVE_W-1:0];
                end
                ltc_pkg::REG_FULL_BRIGHT:
                begin
                    full_bright_reg <= cfg.data[0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Active count saturates at MAX_STYLES
    logic [ltc_pkg::ACTIVE_W-1:0] active_eff;
    assign active_eff = (active_reg > ACTIVE_MAX) ? ACTIVE_MAX : active_reg;

    // ------------------------------------------------------------------
    // Stage 1: per style, per channel products (inactive styles give zero)
    // ------------------------------------------------------------------
    logic [ltc_pkg::SAMPLE_W-1:0] sample [ltc_pkg::STYLE_SLOTS];
    logic [ltc_pkg::PROD_W-1:0]   prod_next [MAX_STYLES][CH];
    logic [ltc_pkg::PROD_W-1:0]   prod_reg  [MAX_STYLES][CH];
    logic                         s1_fb_reg;
    logic                         s1_valid_reg;
    logic                         s1_ready;

    assign sample[0] = texel.sample_style0;
    assign sample[1] = texel.sample_style1;
    assign sample[2] = texel.sample_style2;
    assign sample[3] = texel.sample_style3;

    always_comb
    begin
        logic [CW-1:0] byte_val;
        logic [SW-1:0] scale_val;
        for (int s = 0; s < MAX_STYLES; s++)
        begin
            for (int c = 0; c < CH; c++)
            begin
                byte_val  = sample[s][CW*c +: CW];
                scale_val = scale_reg[s][SW*c +: SW];
                if (ltc_pkg::ACTIVE_W'(s) < active_eff)
                begin
                    prod_next[s][c] = ltc_pkg::PROD_W'(byte_val) *
                                      ltc_pkg::PROD_W'(scale_val);
                end
                else
                begin
                    prod_next[s][c] = '0;
                end
            end
        end
    end

    assign texel.ready = s1_ready;

    // ------------------------------------------------------------------
    // Stage 2: sum the styles and truncate to integer
    // ------------------------------------------------------------------
    logic [V_W-1:0] chan_next [CH];
    logic [V_W-1:0] chan_reg  [CH];
    logic           s2_fb_reg;
    logic           s2_valid_reg;
    logic           s2_ready;

    always_comb
    begin
        logic [SUM_W-1:0] sum;
        for (int c = 0; c < CH; c++)
        begin
            sum = '0;
            for (int s = 0; s < MAX_STYLES; s++)
            begin
                sum = sum + SUM_W'(prod_reg[s][c]);
            end
            chan_next[c] = V_W'(sum >> SCALE_FRAC_BITS);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: find the brightest channel and set up the division.
    // Out of range: num = v*255, den = max. In range: num = v*256, den = 256,
    // which passes v through. Full bright: num = 255*256, den = 256.
    // ------------------------------------------------------------------
    logic [NUM_W-1:0] num_next [LANES];
    logic [DEN_W-1:0] den_next [LANES];
    logic [NUM_W-1:0] num_reg  [LANES];
    logic [DEN_W-1:0] den_reg  [LANES];
    logic             s3_valid_reg;
    logic             s3_ready;

    always_comb
    begin
        logic [V_W-1:0]   peak;
        logic             over;
        logic [V_W-1:0]   level [LANES];
        logic [NUM_W-1:0] shifted;
        peak = (chan_reg[ltc_pkg::LANE_RED] > chan_reg[ltc_pkg::LANE_GREEN])
             ? chan_reg[ltc_pkg::LANE_RED] : chan_reg[ltc_pkg::LANE_GREEN];
        if (chan_reg[ltc_pkg::LANE_BLUE] > peak)
        begin
            peak = chan_reg[ltc_pkg::LANE_BLUE];
        end
        over = peak > V_W'(ltc_pkg::CHAN_MAX);
        for (int c = 0; c < CH; c++)
        begin
            level[c] = chan_reg[c];
        end
        level[ltc_pkg::LANE_ALPHA] = peak;
        for (int l = 0; l < LANES; l++)
        begin
            shifted = {level[l], ltc_pkg::QUOT_W'(0)};
            priority if (s2_fb_reg)
            begin
                num_next[l] = NUM_W'({ltc_pkg::CHAN_MAX, ltc_pkg::QUOT_W'(0)});
                den_next[l] = DEN_W'(1) << ltc_pkg::QUOT_W;
            end
            else if (over)
            begin
                num_next[l] = shifted - NUM_W'(level[l]);
                den_next[l] = peak;
            end
            else
            begin
                num_next[l] = shifted;
                den_next[l] = DEN_W'(1) << ltc_pkg::QUOT_W;
            end
        end
    end

    // ------------------------------------------------------------------
    // Handshake: a stage takes a beat when empty or when its beat moves on
    // ------------------------------------------------------------------
    logic div_in_ready;

    assign s3_ready = !s3_valid_reg || div_in_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= texel.valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    // Payload: load only on a real beat, hold otherwise
    always_ff @(posedge clk)
    begin
        if (s1_ready && texel.valid)
        begin
            prod_reg  <= prod_next;
            s1_fb_reg <= full_bright_reg;
        end
        if (s2_ready && s1_valid_reg)
        begin
            chan_reg  <= chan_next;
            s2_fb_reg <= s1_fb_reg;
        end
        if (s3_ready && s2_valid_reg)
        begin
            num_reg <= num_next;
            den_reg <= den_next;
        end
    end

    // ------------------------------------------------------------------
    // Stages 4 to 11: normalising divider; its last stage is the output
    // ------------------------------------------------------------------
    logic [ltc_pkg::QUOT_W-1:0] quot [LANES];

    ltc_div #(
        .LANES  (LANES),
        .NUM_W  (NUM_W),
        .DEN_W  (DEN_W),
        .QUOT_W (ltc_pkg::QUOT_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s3_valid_reg),
        .in_ready  (div_in_ready),
        .in_num    (num_reg),
        .in_den    (den_reg),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_quot  (quot)
    );

    assign result.red_out   = quot[ltc_pkg::LANE_RED];
    assign result.green_out = quot[ltc_pkg::LANE_GREEN];
    assign result.blue_out  = quot[ltc_pkg::LANE_BLUE];
    assign result.alpha_out = quot[ltc_pkg::LANE_ALPHA];

endmodule

// File: rtl/ltc_checker.sv
// ----------------------------------------------------------------------------
// ltc_checker
// Port-level checks on the texel combiner, bound to the top level.
// ----------------------------------------------------------------------------
module ltc_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       texel_ready,
    input logic                       result_valid,
    input logic                       result_ready,
    input logic [ltc_pkg::CHAN_W-1:0] red_out,
    input logic [ltc_pkg::CHAN_W-1:0] green_out,
    input logic [ltc_pkg::CHAN_W-1:0] blue_out,
    input logic [ltc_pkg::CHAN_W-1:0] alpha_out
);

    // Stalled result beat holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(red_out) && $stable(green_out) &&
            $stable(blue_out) && $stable(alpha_out))
        else $error("result beat changed while stalled");

    // Input back-pressure only comes from a stalled, full output
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        !texel_ready |-> result_valid && !result_ready)
        else $error("texel stalled without output back-pressure");

    // Alpha is the brightest channel
    a_alpha_peak: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> alpha_out >= red_out && alpha_out >= green_out &&
                         alpha_out >= blue_out)
        else $error("alpha below a colour channel");

    a_alpha_member: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> alpha_out == red_out || alpha_out == green_out ||
                         alpha_out == blue_out)
        else $error("alpha matches no colour channel");

endmodule

bind lightmap_texel_combine_top ltc_checker u_ltc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .texel_ready  (texel.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .red_out      (result.red_out),
    .green_out    (result.green_out),
    .blue_out     (result.blue_out),
    .alpha_out    (result.alpha_out)
);

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for lightmap_texel_combine_top. Drives texel beats and
// register writes through the block's channels and keeps a cycle-free model
// of the combine, truncate and rescale arithmetic. Every result beat is
// compared lane by lane with the oldest predicted texel. The directed part
// covers the field extremes and the corner settings. The random part runs
// many register settings with idle bursts on both sides and ends with
// back-to-back traffic.
// ----------------------------------------------------------------------------
module testbench;

    localparam int FRAC_BITS   = ltc_pkg::SCALE_FRAC_BITS_DEF;
    localparam int STYLE_LIMIT = ltc_pkg::MAX_STYLES_DEF;

    // 1.0 in the scale format, and a register with 1.0 in every channel
    localparam logic [ltc_pkg::SCALE_W-1:0] SCALE_ONE =
        ltc_pkg::SCALE_W'(1) << FRAC_BITS;
    localparam logic [ltc_pkg::CFG_DATA_W-1:0] SCALES_UNIT =
        {ltc_pkg::NUM_CHAN{SCALE_ONE}};
    localparam logic [ltc_pkg::CFG_DATA_W-1:0] SCALES_MAX  = '1;
    localparam logic [ltc_pkg::CFG_DATA_W-1:0] SCALES_ZERO = '0;
    localparam logic [ltc_pkg::CFG_DATA_W-1:0] SCALES_HALF =
        {ltc_pkg::NUM_CHAN{16'h0080}};

    // Indexes the block decodes to nothing
    localparam logic [ltc_pkg::CFG_INDEX_W-1:0] REG_SPARE6 = 3'd6;
    localparam logic [ltc_pkg::CFG_INDEX_W-1:0] REG_SPARE7 = 3'd7;

    localparam int QUIET_LIMIT   = 2000;  // cycles with no beat on any channel
    localparam int DRAIN_TAIL    = 24;    // slack after the pipeline has drained
    localparam int PRINT_CAP     = 40;
    localparam int PHASES        = 10;
    localparam int PHASE_TEXELS  = 115;
    localparam int STREAM_TEXELS = 150;

    typedef logic [ltc_pkg::STYLE_SLOTS-1:0][ltc_pkg::SAMPLE_W-1:0] texel_t;

    typedef struct packed {
        logic [ltc_pkg::CHAN_W-1:0] red;
        logic [ltc_pkg::CHAN_W-1:0] green;
        logic [ltc_pkg::CHAN_W-1:0] blue;
        logic [ltc_pkg::CHAN_W-1:0] alpha;
    } rgba_t;

    logic clk;
    logic rst_n;

    ltc_cfg_if    cfg_bus ();
    ltc_texel_if  texel_bus ();
    ltc_result_if result_bus ();

    lightmap_texel_combine_top #(
        .MAX_STYLES      (ltc_pkg::MAX_STYLES_DEF),
        .SCALE_FRAC_BITS (ltc_pkg::SCALE_FRAC_BITS_DEF)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_bus),
        .texel  (texel_bus),
        .result (result_bus)
    );

    // Shadow copy of the register file, updated on each accepted write beat
    logic [ltc_pkg::CFG_DATA_W-1:0] scale_reg [ltc_pkg::STYLE_SLOTS];
    logic [ltc_pkg::ACTIVE_W-1:0]   active_reg;
    logic                           bright_reg;

    // Predicted pixels, oldest first
    rgba_t pending_rgba [$];

    int n_texels;
    int n_results;
    int n_writes;
    int n_settings;
    int n_rescaled;
    int n_bright;
    int n_errors;
    int quiet_cycles = 0;

    // Idle-burst switches for the texel sender and the result receiver
    bit feed_gaps;
    bit sink_stalls;

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Pixel prediction
    // ------------------------------------------------------------------------

    // Sum the scaled bytes of the active styles, drop the fraction, take the
    // brightest channel as alpha and pull everything back to at most 255 when the
    // brightest channel overshoots. Full bright gives 255 in every lane.
    function automatic rgba_t combine_texel(texel_t t, output bit rescaled);
        logic [31:0] acc [ltc_pkg::NUM_CHAN];
        logic [31:0] lvl [ltc_pkg::NUM_LANES];
        logic [31:0] byte_v;
        logic [31:0] scale_v;
        logic [31:0] peak;
        int          n;
        rgba_t       px;
        rescaled = 1'b0;
        if (bright_reg)
        begin
            px = {ltc_pkg::NUM_LANES{ltc_pkg::CHAN_MAX}};
            return px;
        end
        // counts above the style limit saturate
        n = (active_reg > STYLE_LIMIT) ? STYLE_LIMIT : int'(active_reg);
        for (int c = 0; c < ltc_pkg::NUM_CHAN; c++)
            acc[c] = '0;
        for (int s = 0; s < n; s++)
        begin
            for (int c = 0; c < ltc_pkg::NUM_CHAN; c++)
            begin
                byte_v  = 32'(t[s][c*ltc_pkg::CHAN_W +: ltc_pkg::CHAN_W]);
                scale_v = 32'(scale_reg[s][c*ltc_pkg::SCALE_W +: ltc_pkg::SCALE_W]);
                acc[c]  = acc[c] + byte_v * scale_v;
            end
        end
        for (int c = 0; c < ltc_pkg::NUM_CHAN; c++)
            lvl[c] = acc[c] >> FRAC_BITS;
        peak = (lvl[ltc_pkg::LANE_RED] > lvl[ltc_pkg::LANE_GREEN])
             ? lvl[ltc_pkg::LANE_RED] : lvl[ltc_pkg::LANE_GREEN];
        if (lvl[ltc_pkg::LANE_BLUE] > peak)
            peak = lvl[ltc_pkg::LANE_BLUE];
        lvl[ltc_pkg::LANE_ALPHA] = peak;
        if (peak > ltc_pkg::CHAN_MAX)
        begin
            rescaled = 1'b1;
            for (int l = 0; l < ltc_pkg::NUM_LANES; l++)
                lvl[l] = (lvl[l] * ltc_pkg::CHAN_MAX) / peak;
        end
        px.red   = lvl[ltc_pkg::LANE_RED][ltc_pkg::CHAN_W-1:0];
        px.green = lvl[ltc_pkg::LANE_GREEN][ltc_pkg::CHAN_W-1:0];
        px.blue  = lvl[ltc_pkg::LANE_BLUE][ltc_pkg::CHAN_W-1:0];
        px.alpha = lvl[ltc_pkg::LANE_ALPHA][ltc_pkg::CHAN_W-1:0];
        return px;
    endfunction

    function automatic void load_reset_values();
        for (int s = 0; s < ltc_pkg::STYLE_SLOTS; s++)
            scale_reg[s] = SCALES_UNIT;
        active_reg = ltc_pkg::ACTIVE_W'(1);
        bright_reg = 1'b0;
    endfunction

    // Mirror a register write; bits above a register's width fall away
    function automatic void apply_reg(logic [ltc_pkg::CFG_INDEX_W-1:0] idx,
                                      logic [ltc_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            ltc_pkg::REG_SCALE_STYLE0:  scale_reg[0] = data;
            ltc_pkg::REG_SCALE_STYLE1:  scale_reg[1] = data;
            ltc_pkg::REG_SCALE_STYLE2:  scale_reg[2] = data;
            ltc_pkg::REG_SCALE_STYLE3:  scale_reg[3] = data;
            ltc_pkg::REG_ACTIVE_STYLES: active_reg   = data[ltc_pkg::ACTIVE_W-1:0];
            ltc_pkg::REG_FULL_BRIGHT:   bright_reg   = data[0];
            default:                    ;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Random values
    // ------------------------------------------------------------------------
    function automatic logic [ltc_pkg::CFG_DATA_W-1:0] rand_word48();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[ltc_pkg::CFG_DATA_W-1:0];
    endfunction

    // Lean on zero, full scale, unity and small factors as well as the
    // whole range
    function automatic logic [ltc_pkg::SCALE_W-1:0] rand_scale_chan();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return SCALE_ONE;
            3, 4:    return ltc_pkg::SCALE_W'($urandom_range(0, 511));
            default: return ltc_pkg::SCALE_W'($urandom);
        endcase
    endfunction

    function automatic logic [ltc_pkg::CFG_DATA_W-1:0] rand_scale_reg();
        return {rand_scale_chan(), rand_scale_chan(), rand_scale_chan()};
    endfunction

    function automatic logic [ltc_pkg::SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return '1;
            2:       return 24'hFF << (ltc_pkg::CHAN_W * $urandom_range(0, 2));
            default: return ltc_pkg::SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic texel_t mk_texel(logic [ltc_pkg::SAMPLE_W-1:0] s0, s1, s2, s3);
        texel_t t;
        t[0] = s0;
        t[1] = s1;
        t[2] = s2;
        t[3] = s3;
        return t;
    endfunction

    function automatic texel_t rand_texel();
        return mk_texel(rand_sample(), rand_sample(), rand_sample(), rand_sample());
    endfunction

    // ------------------------------------------------------------------------
    // Mismatch reporting
    // ------------------------------------------------------------------------
    task automatic report(string msg);
        n_errors++;
        if (n_errors <= PRINT_CAP)
            $display("%0t ns  mismatch: %s", $time, msg);
    endtask

    task automatic check_lane(string lane, logic [ltc_pkg::CHAN_W-1:0] want,
                              logic [ltc_pkg::CHAN_W-1:0] got);
        if (got !== want)
            report($sformatf("result %0d %s: expected %0d, got %0d",
                             n_results, lane, want, got));
    endtask

    // ------------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------------

    // Present one texel, hold it until accepted, then log its prediction.
    // Valid stays high afterwards unless an idle burst is drawn, so
    // back-to-back calls stream one beat per clock while texel ready stays high.
    task automatic send_texel(texel_t t);
        bit    over;
        rgba_t px;
        texel_bus.valid         <= 1'b1;
        texel_bus.sample_style0 <= t[0];
        texel_bus.sample_style1 <= t[1];
        texel_bus.sample_style2 <= t[2];
        texel_bus.sample_style3 <= t[3];
        do
            @(posedge clk);
        while (!texel_bus.ready);
        px = combine_texel(t, over);
        pending_rgba.push_back(px);
        n_texels++;
        if (over)
            n_rescaled++;
        if (bright_reg)
            n_bright++;
        if (feed_gaps && $urandom_range(0, 5) == 0)
        begin
            texel_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
    endtask

    // Drop valid and hold until every predicted pixel has come back
    task automatic wait_drain();
        texel_bus.valid <= 1'b0;
        while (pending_rgba.size() != 0)
            @(posedge clk);
    endtask

    // Leaves cfg valid high; the caller drops it after its last write
    task automatic write_reg(logic [ltc_pkg::CFG_INDEX_W-1:0] idx,
                             logic [ltc_pkg::CFG_DATA_W-1:0] data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        apply_reg(idx, data);
        n_writes++;
    endtask

    // Reprogram the whole register file with the pipeline empty
    task automatic set_config(logic [ltc_pkg::CFG_DATA_W-1:0] s0, s1, s2, s3,
                              act, bright);
        wait_drain();
        write_reg(ltc_pkg::REG_SCALE_STYLE0, s0);
        write_reg(ltc_pkg::REG_SCALE_STYLE1, s1);
        write_reg(ltc_pkg::REG_SCALE_STYLE2, s2);
        write_reg(ltc_pkg::REG_SCALE_STYLE3, s3);
        write_reg(ltc_pkg::REG_ACTIVE_STYLES, act);
        write_reg(ltc_pkg::REG_FULL_BRIGHT, bright);
        cfg_bus.valid <= 1'b0;
        n_settings++;
    endtask

    // Random setting; the narrow registers carry junk in their upper bits
    task automatic program_random();
        logic [ltc_pkg::CFG_DATA_W-1:0] act;
        logic [ltc_pkg::CFG_DATA_W-1:0] bright;
        act    = rand_word48();
        bright = rand_word48();
        case ($urandom_range(0, 9))
            0:       act[ltc_pkg::ACTIVE_W-1:0] = '0;
            1:       act[ltc_pkg::ACTIVE_W-1:0] =
                         ltc_pkg::ACTIVE_W'($urandom_range(STYLE_LIMIT + 1, 7));
            default: act[ltc_pkg::ACTIVE_W-1:0] =
                         ltc_pkg::ACTIVE_W'($urandom_range(1, STYLE_LIMIT));
        endcase
        bright[0] = ($urandom_range(0, 9) == 0);
        set_config(rand_scale_reg(), rand_scale_reg(), rand_scale_reg(),
                   rand_scale_reg(), act, bright);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset state: unity scales, one style, full bright off. Styles 1..3
    // carry junk that must be ignored.
    task automatic test_reset_defaults();
        send_texel(mk_texel(24'h000000, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
        send_texel(mk_texel(24'hFFFFFF, 24'h000000, 24'h000000, 24'h000000));
        send_texel(mk_texel(24'h123456, rand_sample(), rand_sample(), rand_sample()));
        send_texel(mk_texel(24'h80017F, rand_sample(), rand_sample(), rand_sample()));
    endtask

    task automatic test_directed_extremes();
        // full-scale factors on every style: the largest sums, all rescaled
        set_config(SCALES_MAX, SCALES_MAX, SCALES_MAX, SCALES_MAX, 48'd4, 48'd0);
        send_texel(mk_texel(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
        send_texel(mk_texel(24'h0000FF, 24'h000000, 24'h000000, 24'h000000));
        send_texel(mk_texel(24'h010203, 24'h000100, 24'h000000, 24'h0000FF));

        // zero factors swallow full-scale samples
        set_config(SCALES_ZERO, SCALES_ZERO, SCALES_ZERO, SCALES_ZERO, 48'd4, 48'd0);
        send_texel(mk_texel(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));

        // unity factors: a sum of exactly 255 passes, 256 is rescaled
        set_config(SCALES_UNIT, SCALES_UNIT, SCALES_UNIT, SCALES_UNIT, 48'd4, 48'd0);
        send_texel(mk_texel(24'h3F3F3F, 24'h404040, 24'h404040, 24'h404040));
        send_texel(mk_texel(24'h404040, 24'h404040, 24'h404040, 24'h404040));

        // no styles at all: every lane is zero
        set_config(SCALES_UNIT, SCALES_UNIT, SCALES_UNIT, SCALES_UNIT,
                   48'hFFFF_FFFF_FFF8, 48'd0);
        send_texel(mk_texel(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
        send_texel(rand_texel());

        // style counts past the limit saturate to all four
        set_config(SCALES_UNIT, SCALES_UNIT, SCALES_UNIT, SCALES_UNIT, 48'd5, 48'd0);
        send_texel(mk_texel(24'h102030, 24'h0A0B0C, 24'h010101, 24'h202020));
        set_config(SCALES_UNIT, SCALES_UNIT, SCALES_UNIT, SCALES_UNIT,
                   48'h8000_0000_0006, 48'd0);
        send_texel(mk_texel(24'hFF0000, 24'h00FF00, 24'h0000FF, 24'h808080));
        set_config(SCALES_UNIT, SCALES_UNIT, SCALES_UNIT, SCALES_UNIT,
                   48'hA5A5_A5A5_A5A7, 48'd0);
        send_texel(rand_texel());

        // full bright: only bit 0 counts, and when set it beats everything
        set_config(SCALES_MAX, SCALES_MAX, SCALES_MAX, SCALES_MAX, 48'd4,
                   48'hFFFF_FFFF_FFFE);
        send_texel(mk_texel(24'h7F7F7F, 24'h000000, 24'h000000, 24'h000000));
        set_config(SCALES_ZERO, SCALES_ZERO, SCALES_ZERO, SCALES_ZERO, 48'd0, 48'd1);
        send_texel(mk_texel(24'h000000, 24'h000000, 24'h000000, 24'h000000));

        // fractional factors: the fraction is truncated only after the sum
        set_config(SCALES_HALF, {ltc_pkg::NUM_CHAN{16'h0001}}, SCALES_UNIT,
                   SCALES_UNIT, 48'd2, 48'd0);
        send_texel(mk_texel(24'h030201, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
        send_texel(mk_texel(24'h010101, 24'h808080, 24'h000000, 24'h000000));
    endtask

    // Writes to undecoded indexes must leave the register file untouched
    task automatic test_spare_indexes();
        wait_drain();
        write_reg(REG_SPARE6, rand_word48());
        write_reg(REG_SPARE7, rand_word48());
        cfg_bus.valid <= 1'b0;
        repeat (8) send_texel(rand_texel());
    endtask

    task automatic test_random_phases();
        for (int p = 0; p < PHASES; p++)
        begin
            feed_gaps   = ($urandom_range(0, 3) != 0);
            sink_stalls = ($urandom_range(0, 3) != 0);
            if (p == 0)
                set_config(SCALES_MAX, SCALES_MAX, SCALES_MAX, SCALES_MAX,
                           48'd4, 48'd0);
            else if (p == 1)
                set_config(rand_scale_reg(), SCALES_ZERO, SCALES_MAX,
                           rand_scale_reg(), 48'd7, 48'd0);
            else
                program_random();
            for (int i = 0; i < PHASE_TEXELS; i++)
            begin
                // now and then hold off until the pipeline has emptied
                if ((p == PHASES / 2 && i == PHASE_TEXELS / 2) ||
                    $urandom_range(0, 149) == 0)
                    wait_drain();
                send_texel(rand_texel());
            end
        end
    endtask

    // Last stretch: no gaps, no stalls, one beat per clock
    task automatic test_back_to_back();
        feed_gaps   = 1'b0;
        sink_stalls = 1'b0;
        program_random();
        repeat (STREAM_TEXELS) send_texel(rand_texel());
    endtask

    // ------------------------------------------------------------------------
    // Result receiver: ready drops in random bursts while stalls are enabled
    // ------------------------------------------------------------------------
    initial
    begin
        result_bus.ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (sink_stalls && $urandom_range(0, 7) == 0)
            begin
                result_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            result_bus.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: compare each result beat with the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        rgba_t want;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            n_results++;
            if (pending_rgba.size() == 0)
                report($sformatf("result %0d arrived with no texel pending",
                                 n_results));
            else
            begin
                want = pending_rgba.pop_front();
                check_lane("red",   want.red,   result_bus.red_out);
                check_lane("green", want.green, result_bus.green_out);
                check_lane("blue",  want.blue,  result_bus.blue_out);
                check_lane("alpha", want.alpha, result_bus.alpha_out);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run when no channel has moved a beat for too long
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if ((texel_bus.valid && texel_bus.ready) ||
            (result_bus.valid && result_bus.ready) ||
            (cfg_bus.valid && cfg_bus.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                     quiet_cycles, pending_rgba.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n                   <= 1'b0;
        cfg_bus.valid           <= 1'b0;
        cfg_bus.index           <= ltc_pkg::REG_SCALE_STYLE0;
        cfg_bus.data            <= '0;
        texel_bus.valid         <= 1'b0;
        texel_bus.sample_style0 <= '0;
        texel_bus.sample_style1 <= '0;
        texel_bus.sample_style2 <= '0;
        texel_bus.sample_style3 <= '0;
        feed_gaps   = 1'b1;
        sink_stalls = 1'b1;
        load_reset_values();

        // hold reset, then release it on a clock edge
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_directed_extremes();
        test_spare_indexes();
        test_random_phases();
        test_back_to_back();

        // let the pipeline empty, then allow a little slack for stray beats
        wait_drain();
        repeat (DRAIN_TAIL) @(posedge clk);

        $display("checked %0d texels against %0d result beats, %0d register writes",
                 n_texels, n_results, n_writes);
        $display("%0d register settings, %0d texels rescaled, %0d in full bright",
                 n_settings, n_rescaled, n_bright);
        if (n_errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: files.f
rtl/ltc_pkg.sv
rtl/ltc_cfg_if.sv
rtl/ltc_texel_if.sv
rtl/ltc_result_if.sv
rtl/ltc_div.sv
rtl/lightmap_texel_combine_top.sv
rtl/ltc_checker.sv
tb/testbench.sv
